// ===== rtl/plate_watchlist_fuzzy_matcher_core_macros.svh =====
// Assertion macros shared by the watchlist matcher.
`ifndef PLATE_WATCHLIST_FUZZY_MATCHER_CORE_MACROS_SVH
`define PLATE_WATCHLIST_FUZZY_MATCHER_CORE_MACROS_SVH
`define PWM_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define PWM_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== rtl/pwm_pkg.sv =====
// Types and constants of the plate watchlist matcher.
package pwm_pkg;
	localparam logic [2:0] ACT_ADD = 3'd0;
	localparam logic [2:0] ACT_REMOVE = 3'd1;
	localparam logic [2:0] ACT_EXACT = 3'd2;
	localparam logic [2:0] ACT_FUZZY = 3'd3;
	localparam logic [2:0] ACT_PREFIX = 3'd4;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;
	localparam logic [1:0] KIND_BLOCKED = 2'd0;
	localparam logic [1:0] KIND_BAD = 2'd3;

	typedef struct packed {
		logic [2:0] action;
		logic [63:0] text;
		logic [3:0] len;
		logic [1:0] kind;
		logic alert;
		logic [15:0] handle;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] slot;
		logic [63:0] plate;
		logic [3:0] len;
		logic [1:0] kind;
		logic alert;
		logic [15:0] handle;
	} res_t;

	// Lexicographic less-than with unsigned bytes; a proper prefix sorts first.
	function automatic logic plate_less(input logic [63:0] a, input logic [3:0] la,
			input logic [63:0] b, input logic [3:0] lb);
		logic done;
		logic r;
		done = 1'b0;
		r = la < lb;
		for (int i = 0; i < 8; i++) begin
			if (!done && i < la && i < lb && a[8*i +: 8] != b[8*i +: 8]) begin
				done = 1'b1;
				r = a[8*i +: 8] < b[8*i +: 8];
			end
		end
		plate_less = r;
	endfunction

	function automatic logic one_edit(input logic [63:0] a, input logic [3:0] la,
			input logic [63:0] b, input logic [3:0] lb);
		logic [63:0] lo;
		logic [63:0] sh;
		logic [3:0] ll;
		logic [3:0] sl;
		logic [3:0] diffs;
		logic ok;
		logic skipped;
		ok = 1'b0;
		if (la == lb) begin
			diffs = 4'd0;
			for (int i = 0; i < 8; i++)
				if (i < la && a[8*i +: 8] != b[8*i +: 8])
					diffs = diffs + 4'd1;
			ok = diffs <= 4'd1;
		end else if (la == lb + 4'd1 || lb == la + 4'd1) begin
			lo = (la > lb) ? a : b;
			ll = (la > lb) ? la : lb;
			sh = (la > lb) ? b : a;
			sl = (la > lb) ? lb : la;
			// The shorter plate must match the longer one with one character skipped.
			skipped = 1'b0;
			ok = 1'b1;
			for (int j = 0; j < 8; j++) begin
				if (j < sl) begin
					if (!skipped && sh[8*j +: 8] != lo[8*j +: 8])
						skipped = 1'b1;
					if (skipped && j + 1 < 8 && sh[8*j +: 8] != lo[8*(j+1) +: 8])
						ok = 1'b0;
				end
			end
			if (ll == 4'd0)
				ok = 1'b0;
		end
		one_edit = ok && la != 4'd0 && lb != 4'd0;
	endfunction

	function automatic logic [3:0] shared_prefix(input logic [63:0] a, input logic [3:0] la,
			input logic [63:0] b, input logic [3:0] lb);
		logic stop;
		logic [3:0] n;
		stop = 1'b0;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (!stop && i < la && i < lb && a[8*i +: 8] == b[8*i +: 8])
				n = n + 4'd1;
			else
				stop = 1'b1;
		end
		shared_prefix = n;
	endfunction
endpackage

// ===== rtl/pwm_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module pwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/pwm_front.sv =====
// Front end: takes items, normalizes them and queues them for the scanner.
module pwm_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [2:0] action,
	input logic [63:0] plate_text,
	input logic [3:0] plate_length,
	input logic [1:0] flag_kind,
	input logic raise_alert,
	input logic [15:0] record_handle,
	output logic cmd_valid,
	output pwm_pkg::cmd_t cmd,
	input logic cmd_take
);
	pwm_pkg::cmd_t q_q [2];
	logic [1:0] cnt_q;
	logic rd_q;
	logic wr_q;
	pwm_pkg::cmd_t norm;
	logic [3:0] len;
	logic [63:0] mask;
	logic do_push;

	always_comb begin
		len = (plate_length > 4'd8) ? 4'd8 : plate_length;
		for (int i = 0; i < 8; i++)
			mask[8*i +: 8] = (i < len) ? 8'hFF : 8'h00;
		norm.action = action;
		norm.text = plate_text & mask;
		norm.len = len;
		norm.kind = (flag_kind == pwm_pkg::KIND_BAD) ? pwm_pkg::KIND_BLOCKED : flag_kind;
		norm.alert = raise_alert;
		norm.handle = record_handle;
	end

	assign full = cnt_q == 2'd2;
	assign do_push = push && !full;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = q_q[rd_q];

	always_ff @(posedge clk)
		if (do_push)
			q_q[wr_q] <= norm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (cmd_take)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, cmd_take};
		end
	end
endmodule

// ===== rtl/pwm_back.sv =====
// Back end: scans the table memory for each item and writes results.
module pwm_back #(
	parameter int TABLE_ENTRIES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic [3:0] min_prefix_chars,
	input logic cmd_valid,
	input pwm_pkg::cmd_t cmd,
	output logic cmd_take,
	output logic res_valid,
	output pwm_pkg::res_t res,
	input logic res_take
);
	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int EW = 64 + 4 + 2 + 1 + 16;
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_LAST = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	pwm_pkg::cmd_t cmd_q;
	logic [AW:0] addr_q;
	logic [AW-1:0] rslot_q;
	logic rd_live_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic best_ok_q;
	logic [AW-1:0] best_q;
	logic [EW-1:0] best_e_q;
	logic free_ok_q;
	logic [AW-1:0] free_q;
	logic [EW-1:0] rdata;
	logic [63:0] rp;
	logic [3:0] rl;
	logic hit;
	logic better;
	logic we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic out_full_q;
	pwm_pkg::res_t res_q;
	pwm_pkg::res_t fin;
	logic [AW-1:0] tgt;

	pwm_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(addr_q[AW-1:0]), .rdata(rdata)
	);

	assign rp = rdata[EW-1 -: 64];
	assign rl = rdata[22:19];

	always_comb begin
		unique case (cmd_q.action)
			pwm_pkg::ACT_FUZZY:
				hit = pwm_pkg::one_edit(cmd_q.text, cmd_q.len, rp, rl);
			pwm_pkg::ACT_PREFIX:
				hit = cmd_q.len >= min_prefix_chars &&
					pwm_pkg::shared_prefix(cmd_q.text, cmd_q.len, rp, rl) >= min_prefix_chars;
			default:
				hit = cmd_q.len == rl && cmd_q.text == rp;
		endcase
		hit = hit && rd_live_q && valid_q[rslot_q];
	end

	assign better = hit && (!best_ok_q || pwm_pkg::plate_less(rp, rl,
		best_e_q[EW-1 -: 64], best_e_q[22:19]));

	always_comb begin
		tgt = best_ok_q ? best_q : free_q;
		fin = '0;
		we = 1'b0;
		waddr = tgt;
		wdata = {cmd_q.text, cmd_q.len, cmd_q.kind, cmd_q.alert, cmd_q.handle};
		if (cmd_q.action == pwm_pkg::ACT_ADD) begin
			if (best_ok_q || free_ok_q) begin
				we = state_q == S_DONE && !out_full_q;
				fin.status = pwm_pkg::ST_OK;
				fin.slot = 6'(tgt);
				{fin.plate, fin.len, fin.kind, fin.alert, fin.handle} = wdata;
			end else
				fin.status = pwm_pkg::ST_FULL;
		end else if (cmd_q.action > pwm_pkg::ACT_PREFIX || !best_ok_q) begin
			fin.status = pwm_pkg::ST_MISS;
		end else begin
			fin.status = pwm_pkg::ST_OK;
			fin.slot = 6'(best_q);
			{fin.plate, fin.len, fin.kind, fin.alert, fin.handle} = best_e_q;
		end
	end

	assign cmd_take = state_q == S_IDLE && cmd_valid;
	assign res_valid = out_full_q;
	assign res = res_q;

	always_ff @(posedge clk) begin
		if (cmd_take)
			cmd_q <= cmd;
		if (better)
			best_e_q <= rdata;
		if (state_q == S_DONE && !out_full_q)
			res_q <= fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			addr_q <= '0;
			rslot_q <= '0;
			rd_live_q <= 1'b0;
			valid_q <= '0;
			best_ok_q <= 1'b0;
			best_q <= '0;
			free_ok_q <= 1'b0;
			free_q <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (res_take)
				out_full_q <= 1'b0;
			rslot_q <= addr_q[AW-1:0];
			rd_live_q <= state_q == S_SCAN;
			if (better) begin
				best_ok_q <= 1'b1;
				best_q <= rslot_q;
			end
			if (rd_live_q && !valid_q[rslot_q] && !free_ok_q) begin
				free_ok_q <= 1'b1;
				free_q <= rslot_q;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						state_q <= S_SCAN;
						addr_q <= '0;
						best_ok_q <= 1'b0;
						free_ok_q <= 1'b0;
					end
				end
				S_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == (AW+1)'(TABLE_ENTRIES - 1))
						state_q <= S_LAST;
				end
				S_LAST: state_q <= S_DONE;
				S_DONE: begin
					if (!out_full_q) begin
						out_full_q <= 1'b1;
						state_q <= S_IDLE;
						if (we)
							valid_q[tgt] <= 1'b1;
						if (cmd_q.action == pwm_pkg::ACT_REMOVE && best_ok_q)
							valid_q[best_q] <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/plate_watchlist_fuzzy_matcher_core.sv =====
// Plate watchlist matcher top level with configuration register and checks.
// Each item is queued by the front end, then the back end reads every table slot
// from one memory port, one slot a cycle, keeping the smallest matching plate and the
// lowest free slot; it takes a new item only once the last result is registered.
// Results wait in an output register until popped.
module plate_watchlist_fuzzy_matcher_core #(
	parameter int TABLE_ENTRIES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [3:0] cfg_wdata,
	input logic push,
	output logic full,
	input logic [2:0] action,
	input logic [63:0] plate_text,
	input logic [3:0] plate_length,
	input logic [1:0] flag_kind,
	input logic raise_alert,
	input logic [15:0] record_handle,
	output logic empty,
	input logic pop,
	output logic [1:0] status,
	output logic [5:0] match_slot,
	output logic [63:0] match_plate,
	output logic [3:0] match_length,
	output logic [1:0] match_kind,
	output logic match_alert,
	output logic [15:0] match_handle
);
	`include "plate_watchlist_fuzzy_matcher_core_macros.svh"

	logic [3:0] min_prefix_q;
	logic cmd_valid;
	logic cmd_take;
	pwm_pkg::cmd_t cmd;
	logic res_valid;
	pwm_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			min_prefix_q <= 4'd3;
		else if (cfg_we)
			min_prefix_q <= cfg_wdata;
	end

	pwm_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.plate_text(plate_text), .plate_length(plate_length), .flag_kind(flag_kind),
		.raise_alert(raise_alert), .record_handle(record_handle),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	pwm_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n), .min_prefix_chars(min_prefix_q),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
		.res_valid(res_valid), .res(res), .res_take(pop && !empty)
	);

	assign empty = !res_valid;
	assign status = res.status;
	assign match_slot = res.slot;
	assign match_plate = res.plate;
	assign match_length = res.len;
	assign match_kind = res.kind;
	assign match_alert = res.alert;
	assign match_handle = res.handle;

	`PWM_ASSERT_IMP(a_take_needs_valid, clk, arst_n, cmd_take, cmd_valid, "take from empty queue")
	`PWM_ASSERT_IMP(a_miss_zero, clk, arst_n, !empty && status != pwm_pkg::ST_OK, match_handle == 16'd0 && match_slot == 6'd0, "miss result not zero")
	`PWM_ASSERT_NXT(a_hold_result, clk, arst_n, !empty && !pop, !empty && $stable(status), "result lost while stalled")
endmodule
